FILE: hw/rtl/sshf_pkg.sv
package sshf_pkg;

  localparam int MAX_STOP_LEN  = 8;
  localparam int NUM_STOPS     = 4;
  localparam int NUM_STOP_REGS = 4;
  localparam int BUF_DEPTH     = 8;
  localparam int CNT_W         = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W         = $clog2(BUF_DEPTH);
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN3 = 4'd7;

  typedef logic [BUF_DEPTH-1:0][7:0]          byte_arr_t;
  typedef logic [NUM_STOP_REGS-1:0][63:0]     pat_arr_t;
  typedef logic [NUM_STOP_REGS-1:0][3:0]      len_arr_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stop_hit;
    logic       last;
  } out_item_t;

  typedef struct packed {
    byte_arr_t        rel;
    logic [CNT_W-1:0] rel_cnt;
    logic             hit;
    logic             held_we;
    byte_arr_t        held_next;
    logic [CNT_W-1:0] count_next;
  } calc_res_t;

endpackage

FILE: hw/rtl/sshf_calc.sv
module sshf_calc
  import sshf_pkg::*;
(
  input  in_item_t         item,
  input  byte_arr_t        held,
  input  logic [CNT_W-1:0] held_count,
  input  pat_arr_t         pattern,
  input  len_arr_t         length,
  output calc_res_t        res
);

  localparam logic [7:0] UTF_CONT_MASK  = 8'hC0;
  localparam logic [7:0] UTF_CONT       = 8'h80;
  localparam logic [7:0] UTF_LEAD2_MASK = 8'hE0;
  localparam logic [7:0] UTF_LEAD3_MASK = 8'hF0;
  localparam logic [7:0] UTF_LEAD4_MASK = 8'hF8;

  // length of an unfinished UTF-8 sequence ending the text; c[0] is the last byte
  function automatic logic [2:0] utf8_tail(input logic [3:0][7:0] c,
                                           input logic [CNT_W-1:0] m);
    logic [2:0] cont;
    logic       run;
    logic [7:0] lead;
    logic [2:0] need;
    cont = 3'd0;
    run  = 1'b1;
    need = 3'd0;
    for (int k = 0; k < 3; k++) begin
      if (run && CNT_W'(k) < m && (c[k] & UTF_CONT_MASK) == UTF_CONT) begin
        cont = cont + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    if (CNT_W'(cont) >= m) begin
      return 3'd0;
    end
    lead = c[cont[1:0]];
    if ((lead & UTF_CONT) == 8'h00) begin
      need = 3'd1;
    end else if ((lead & UTF_LEAD2_MASK) == UTF_CONT_MASK) begin
      need = 3'd2;
    end else if ((lead & UTF_LEAD3_MASK) == UTF_LEAD2_MASK) begin
      need = 3'd3;
    end else if ((lead & UTF_LEAD4_MASK) == UTF_LEAD3_MASK) begin
      need = 3'd4;
    end else begin
      return 3'd0;
    end
    return ((cont + 3'd1) < need) ? cont + 3'd1 : 3'd0;
  endfunction

  logic                     append;
  logic [CNT_W-1:0]         count_c;
  logic [CNT_W-1:0]         n0;
  logic [CNT_W-1:0]         m_end;
  byte_arr_t                w;
  logic [3:0][7:0]          t_end;
  logic [BUF_DEPTH-1:0][7:0] t;
  logic [3:0][7:0]          u;
  logic [NUM_STOP_REGS-1:0][3:0] eff;
  logic [BUF_DEPTH-1:0]     match_at;
  logic [CNT_W-1:0]         best;
  logic                     hit;
  logic [2:0]               tail_end;
  logic [2:0]               tail_best;
  logic [CNT_W-1:0]         pt;
  logic [CNT_W-1:0]         hold;
  logic [CNT_W-1:0]         cnt;

  assign append  = (item.opcode == OP_APPEND);
  assign count_c = (held_count > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : held_count;
  assign n0      = (held_count >= CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH - 1) : held_count;
  assign m_end   = append ? n0 + CNT_W'(1) : count_c;

  always_comb begin
    logic [CNT_W-1:0] p;
    for (int j = 0; j < BUF_DEPTH; j++) begin
      w[j] = (append && n0[IDX_W-1:0] == IDX_W'(j)) ? item.in_byte : held[j];
    end
    for (int j = 0; j < BUF_DEPTH; j++) begin
      p    = m_end - CNT_W'(j + 1);
      t[j] = w[p[IDX_W-1:0]];
    end
    for (int j = 0; j < 4; j++) begin
      t_end[j] = t[j];
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_STOP_REGS; s++) begin
      if (s < NUM_STOPS) begin
        eff[s] = (length[s] > 4'(MAX_STOP_LEN)) ? 4'(MAX_STOP_LEN) : length[s];
      end else begin
        eff[s] = 4'd0;
      end
    end
  end

  // every start position against every stop, all in parallel
  always_comb begin
    logic ok;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      match_at[i] = 1'b0;
      for (int s = 0; s < NUM_STOP_REGS; s++) begin
        ok = (eff[s] != 4'd0) && ((i + int'(eff[s])) <= int'(m_end));
        for (int k = 0; k < BUF_DEPTH; k++) begin
          if (k < int'(eff[s]) && w[IDX_W'(i + k)] != pattern[s][8*k +: 8]) begin
            ok = 1'b0;
          end
        end
        match_at[i] = match_at[i] | ok;
      end
    end
  end

  always_comb begin
    best = m_end;
    for (int i = BUF_DEPTH - 1; i >= 0; i--) begin
      if (match_at[i]) begin
        best = CNT_W'(i);
      end
    end
  end

  assign hit = append && (match_at != '0);

  always_comb begin
    logic [CNT_W-1:0] p;
    for (int j = 0; j < 4; j++) begin
      p    = best - CNT_W'(j + 1);
      u[j] = w[p[IDX_W-1:0]];
    end
  end

  assign tail_end  = utf8_tail(t_end, m_end);
  assign tail_best = utf8_tail(u, best);

  // longest held suffix that is a proper prefix of some stop
  always_comb begin
    logic found;
    logic ok;
    pt = '0;
    for (int len = 1; len <= BUF_DEPTH; len++) begin
      found = 1'b0;
      for (int s = 0; s < NUM_STOP_REGS; s++) begin
        ok = (int'(eff[s]) > len) && (len <= int'(m_end));
        for (int k = 0; k < len; k++) begin
          if (t[len - 1 - k] != pattern[s][8*k +: 8]) begin
            ok = 1'b0;
          end
        end
        found = found | ok;
      end
      if (found) begin
        pt = CNT_W'(len);
      end
    end
  end

  assign hold = (pt > CNT_W'(tail_end)) ? pt : CNT_W'(tail_end);
  assign cnt  = m_end - hold;

  always_comb begin
    logic [CNT_W-1:0] p;
    res.rel     = w;
    res.hit     = hit;
    res.held_we = append;
    for (int j = 0; j < BUF_DEPTH; j++) begin
      p                = cnt + CNT_W'(j);
      res.held_next[j] = w[p[IDX_W-1:0]];
    end
    case (item.opcode)
      OP_APPEND: begin
        if (hit) begin
          res.rel_cnt    = best - CNT_W'(tail_best);
          res.count_next = '0;
        end else begin
          res.rel_cnt    = cnt;
          res.count_next = hold;
        end
      end
      OP_FINISH: begin
        res.rel_cnt    = count_c - CNT_W'(tail_end);
        res.count_next = '0;
      end
      OP_CLEAR: begin
        res.rel_cnt    = '0;
        res.count_next = '0;
      end
      default: begin
        res.rel_cnt    = '0;
        res.count_next = held_count;
      end
    endcase
  end

endmodule

FILE: hw/rtl/stop_sequence_holdback_filter_core.sv
// Registers: the item in in_q, its result in the release buffer, each beat in out_q.
// Throughput: one item per cycle while each item yields a single result and out_stall
// is low; an item that releases k bytes holds the release buffer, one beat per byte.
// Reset (rst, synchronous): clears stop config, held count and all valid flags;
// held text bytes are left undefined.
module stop_sequence_holdback_filter_core
  import sshf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pat_arr_t         pattern;
  len_arr_t         length;
  byte_arr_t        held;
  logic [CNT_W-1:0] held_count;

  logic             in_valid_q;
  in_item_t         in_q;

  byte_arr_t        rel_w;
  logic [CNT_W-1:0] rel_cnt;
  logic             rel_hit;
  logic [IDX_W-1:0] rel_idx;
  logic             rel_busy;

  out_item_t        out_q;
  out_item_t        cur;
  calc_res_t        res;

  logic             out_load;
  logic             move;
  logic             cur_last;
  logic             fire;

  sshf_calc u_calc (
    .item       (in_q),
    .held       (held),
    .held_count (held_count),
    .pattern    (pattern),
    .length     (length),
    .res        (res)
  );

  assign cur_last = (rel_cnt == '0) || ({1'b0, rel_idx} == rel_cnt - CNT_W'(1));
  assign cur.out_byte   = (rel_cnt == '0) ? 8'h00 : rel_w[rel_idx];
  assign cur.byte_valid = (rel_cnt != '0);
  assign cur.stop_hit   = rel_hit;
  assign cur.last       = cur_last;

  assign out_load  = !out_valid || !out_stall;
  assign move      = rel_busy && out_load;
  assign fire      = in_valid_q && (!rel_busy || (move && cur_last));
  assign in_stall  = in_valid_q && !fire;
  assign out_item  = out_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      rel_busy   <= 1'b0;
      rel_idx    <= '0;
      out_valid  <= 1'b0;
      held_count <= '0;
      pattern    <= '0;
      length     <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_q <= in_valid;
      end
      if (out_load) begin
        out_valid <= rel_busy;
      end
      if (fire) begin
        rel_busy   <= 1'b1;
        rel_idx    <= '0;
        held_count <= res.count_next;
      end else if (move) begin
        rel_idx <= rel_idx + IDX_W'(1);
        if (cur_last) begin
          rel_busy <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index inside {[CFG_PAT0:CFG_PAT3]}) begin
          pattern[cfg_index[1:0]] <= cfg_data;
        end else if (cfg_index inside {[CFG_LEN0:CFG_LEN3]}) begin
          length[cfg_index[1:0]] <= cfg_data[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
    if (move) begin
      out_q <= cur;
    end
    if (fire) begin
      rel_w   <= res.rel;
      rel_cnt <= res.rel_cnt;
      rel_hit <= res.hit;
      if (res.held_we) begin
        held <= res.held_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(BUF_DEPTH))
    else $error("held count above buffer depth");

  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    fire |=> rel_busy)
    else $error("release buffer not busy after load");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.byte_valid |-> out_q.last)
    else $error("bare marker without last");

  a_rel_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    rel_busy |-> rel_cnt <= CNT_W'(BUF_DEPTH))
    else $error("release count above buffer depth");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !in_valid_q |-> !in_stall)
    else $error("input stalled with empty input register");

endmodule

FILE: tb/tb_stop_sequence_holdback_filter_core.sv
`timescale 1ns / 1ps

module tb_stop_sequence_holdback_filter_core;
  import sshf_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 150;
  localparam int PHASE_ITEMS = 56;
  localparam int NUM_PHASES = 8;

  typedef struct {
    bit is_cfg;
    in_item_t item;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    bit typed;
    out_item_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pat_arr_t stop_pat = '0;
  len_arr_t stop_len = '0;
  byte_arr_t held = '0;
  int held_cnt = 0;

  out_item_t exp_beats[$];
  plan_row_t plan[$];
  int errors = 0;
  int beat_no = 0;
  int items_sent = 0;
  int quiet = 0;
  bit gaps_on = 1'b1;
  bit hold_tog = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  stop_sequence_holdback_filter_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_item_t beat(logic [7:0] b, logic v, logic h, logic l);
    out_item_t r;
    r.out_byte = b;
    r.byte_valid = v;
    r.stop_hit = h;
    r.last = l;
    return r;
  endfunction

  function automatic int active_len(int s);
    int l;
    if (s >= NUM_STOPS) return 0;
    l = stop_len[s];
    return (l > MAX_STOP_LEN) ? MAX_STOP_LEN : l;
  endfunction

  function automatic logic [7:0] stop_char(int s, int k);
    return stop_pat[s][8*k +: 8];
  endfunction

  // length of an unfinished UTF-8 sequence at the end of held[0..n-1]
  function automatic int utf8_pending(int n);
    int cont;
    int need;
    logic [7:0] lead;
    cont = 0;
    while (cont < 3 && cont < n && (held[n-1-cont] & 8'hC0) == 8'h80) cont++;
    if (cont >= n) return 0;
    lead = held[n-1-cont];
    if (lead[7] == 1'b0) need = 1;
    else if ((lead & 8'hE0) == 8'hC0) need = 2;
    else if ((lead & 8'hF0) == 8'hE0) need = 3;
    else if ((lead & 8'hF8) == 8'hF0) need = 4;
    else return 0;
    return (cont + 1 < need) ? cont + 1 : 0;
  endfunction

  function automatic int earliest_stop(int n);
    int best;
    int l;
    bit ok;
    bit found;
    best = n;
    for (int s = 0; s < NUM_STOP_REGS; s++) begin
      l = active_len(s);
      if (l != 0 && l <= n) begin
        found = 1'b0;
        for (int i = 0; i + l <= n && !found; i++) begin
          ok = 1'b1;
          for (int k = 0; k < l; k++)
            if (held[i+k] != stop_char(s, k)) ok = 1'b0;
          if (ok) begin
            found = 1'b1;
            if (i < best) best = i;
          end
        end
      end
    end
    return best;
  endfunction

  // longest tail of held text that is a proper prefix of an active stop
  function automatic int prefix_hold(int n);
    int maxl;
    bit ok;
    maxl = 0;
    for (int s = 0; s < NUM_STOP_REGS; s++)
      if (active_len(s) > maxl) maxl = active_len(s);
    if (maxl > n) maxl = n;
    for (int len = maxl; len > 0; len--) begin
      for (int s = 0; s < NUM_STOP_REGS; s++) begin
        if (active_len(s) > len) begin
          ok = 1'b1;
          for (int k = 0; k < len; k++)
            if (held[n-len+k] != stop_char(s, k)) ok = 1'b0;
          if (ok) return len;
        end
      end
    end
    return 0;
  endfunction

  function automatic void release_bytes(int cnt, bit hit, bit record);
    if (!record) return;
    if (cnt == 0) exp_beats.push_back(beat(8'h00, 1'b0, hit, 1'b1));
    else
      for (int i = 0; i < cnt; i++)
        exp_beats.push_back(beat(held[i], 1'b1, hit, i == cnt - 1));
  endfunction

  function automatic void filter_step(in_item_t it, bit record);
    int n;
    int f;
    int a;
    int b;
    int hold;
    int cnt;
    case (it.opcode)
      OP_CLEAR: begin
        held_cnt = 0;
        release_bytes(0, 1'b0, record);
      end
      OP_FINISH: begin
        n = held_cnt;
        cnt = n - utf8_pending(n);
        release_bytes(cnt, 1'b0, record);
        held_cnt = 0;
      end
      OP_APPEND: begin
        n = (held_cnt >= BUF_DEPTH) ? BUF_DEPTH - 1 : held_cnt;
        held[n] = it.in_byte;
        n++;
        f = earliest_stop(n);
        if (f < n) begin
          cnt = f - utf8_pending(f);
          release_bytes(cnt, 1'b1, record);
          held_cnt = 0;
        end else begin
          a = prefix_hold(n);
          b = utf8_pending(n);
          hold = (a > b) ? a : b;
          cnt = n - hold;
          release_bytes(cnt, 1'b0, record);
          for (int i = 0; i < hold; i++) held[i] = held[cnt+i];
          held_cnt = hold;
        end
      end
      default: release_bytes(0, 1'b0, record);
    endcase
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx <= CFG_PAT3) stop_pat[idx - CFG_PAT0] = data;
    else if (idx <= CFG_LEN3) stop_len[idx - CFG_LEN0] = data[3:0];
  endfunction

  task automatic report(string msg);
    $display("MISMATCH %s", msg);
    errors++;
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    beat_no++;
    if (exp_beats.size() == 0) begin
      report($sformatf("beat %0d: unexpected beat %h", beat_no, got));
      return;
    end
    want = exp_beats.pop_front();
    if (got.out_byte != want.out_byte)
      report($sformatf("beat %0d out_byte got %h want %h", beat_no, got.out_byte,
                       want.out_byte));
    if (got.byte_valid != want.byte_valid)
      report($sformatf("beat %0d byte_valid got %b want %b", beat_no, got.byte_valid,
                       want.byte_valid));
    if (got.stop_hit != want.stop_hit)
      report($sformatf("beat %0d stop_hit got %b want %b", beat_no, got.stop_hit,
                       want.stop_hit));
    if (got.last != want.last)
      report($sformatf("beat %0d last got %b want %b", beat_no, got.last, want.last));
  endtask

  // receiver: checks beats, stalls in bursts, and runs the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_beat(out_item);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_step(it, !typed);
    if (typed) exp_beats.push_back(want);
    items_sent++;
  endtask

  task automatic send_op(logic [1:0] op, logic [7:0] b);
    in_item_t it;
    it.opcode = op;
    it.in_byte = b;
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_item(logic [1:0] op, logic [7:0] b);
    plan_row_t r;
    r = '{default: '0};
    r.item.opcode = op;
    r.item.in_byte = b;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(logic [1:0] op, logic [7:0] b, out_item_t want);
    plan_row_t r;
    r = '{default: '0};
    r.item.opcode = op;
    r.item.in_byte = b;
    r.typed = 1'b1;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic logic [63:0] rand_pattern();
    logic [63:0] p;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 5))
        0: p[8*k +: 8] = 8'h61;
        1: p[8*k +: 8] = 8'h62;
        2: p[8*k +: 8] = 8'h63;
        3: p[8*k +: 8] = 8'hC3;
        4: p[8*k +: 8] = 8'hA9;
        default: p[8*k +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  task automatic program_phase(int ph);
    logic [63:0] p;
    logic [3:0] l;
    for (int s = 0; s < NUM_STOP_REGS; s++) begin
      case (ph)
        0: begin p = '0; l = 4'd8; end
        1: begin p = '1; l = 4'd15; end
        2: begin p = rand_pattern(); l = 4'd0; end
        default: begin
          p = rand_pattern();
          l = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
        end
      endcase
      cfg_write(CFG_IDX_W'(CFG_PAT0 + s), p);
      cfg_write(CFG_IDX_W'(CFG_LEN0 + s),
                {$urandom, $urandom_range(0, 15) & 32'hFFFF_FFF0 | l});
    end
    cfg_write(CFG_IDX_W'(CFG_LEN3 + 1 + $urandom_range(0, 7)), {$urandom, $urandom});
  endtask

  task automatic random_seq();
    int r;
    int s;
    int l;
    int k;
    int need;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      s = $urandom_range(0, NUM_STOP_REGS - 1);
      l = active_len(s);
      if (l == 0) begin
        send_op(OP_APPEND, 8'($urandom));
      end else begin
        k = $urandom_range(1, l);
        for (int j = 0; j < k; j++) begin
          b = stop_char(s, j);
          if ($urandom_range(0, 9) == 0) b = 8'($urandom);
          send_op(OP_APPEND, b);
        end
      end
    end else if (r < 70) begin
      need = $urandom_range(2, 4);
      case (need)
        2: b = {3'b110, 5'($urandom)};
        3: b = {4'b1110, 4'($urandom)};
        default: b = {5'b11110, 3'($urandom)};
      endcase
      send_op(OP_APPEND, b);
      k = $urandom_range(1, need);
      for (int j = 1; j < k; j++) send_op(OP_APPEND, {2'b10, 6'($urandom)});
    end else if (r < 85) begin
      send_op(OP_APPEND, 8'($urandom));
    end else if (r < 93) begin
      send_op(OP_FINISH, 8'($urandom));
    end else if (r < 97) begin
      send_op(OP_CLEAR, 8'($urandom));
    end else begin
      send_op(OP_RESERVED, 8'($urandom));
    end
  endtask

  initial begin
    int target;
    bit paused;
    out_item_t marker;
    marker = beat(8'h00, 1'b0, 1'b0, 1'b1);
    paused = 1'b0;

    // no stops configured after reset
    add_typed(OP_APPEND, 8'h41, beat(8'h41, 1'b1, 1'b0, 1'b1));
    add_typed(OP_APPEND, 8'h00, beat(8'h00, 1'b1, 1'b0, 1'b1));
    add_typed(OP_APPEND, 8'hFF, beat(8'hFF, 1'b1, 1'b0, 1'b1));
    add_typed(OP_APPEND, 8'hC3, marker);
    add_item(OP_APPEND, 8'hA9);
    add_typed(OP_RESERVED, 8'hFF, marker);
    add_typed(OP_APPEND, 8'hE2, marker);
    add_typed(OP_FINISH, 8'h00, marker);
    add_typed(OP_APPEND, 8'hF0, marker);
    add_typed(OP_CLEAR, 8'hFF, marker);
    add_typed(OP_FINISH, 8'hFF, marker);
    add_typed(OP_APPEND, 8'h80, beat(8'h80, 1'b1, 1'b0, 1'b1));
    // stops: "ab", 8-byte "qrstuvwx" with overlong length, 0xFF, unused
    add_cfg(CFG_PAT0, 64'h6261);
    add_cfg(CFG_LEN0, 64'd2);
    add_cfg(CFG_IDX_W'(CFG_PAT0 + 1), 64'h7877_7675_7473_7271);
    add_cfg(CFG_IDX_W'(CFG_LEN0 + 1), 64'd15);
    add_cfg(CFG_IDX_W'(CFG_PAT0 + 2), 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(CFG_IDX_W'(CFG_LEN0 + 2), 64'd1);
    add_cfg(CFG_PAT3, 64'h0);
    add_cfg(CFG_LEN3, 64'd0);
    add_cfg(4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_item(OP_APPEND, 8'h78);
    add_item(OP_APPEND, 8'h61);
    add_item(OP_APPEND, 8'h62);
    add_item(OP_APPEND, 8'h71);
    add_item(OP_APPEND, 8'h72);
    add_item(OP_APPEND, 8'h73);
    // new stop "rs" must be found inside the held "qrs"
    add_cfg(CFG_PAT0, 64'h7372);
    add_item(OP_APPEND, 8'h7A);
    add_item(OP_APPEND, 8'hFF);
    add_cfg(CFG_PAT0, 64'h6261);
    add_item(OP_APPEND, 8'hC3);
    add_item(OP_APPEND, 8'h61);
    add_item(OP_APPEND, 8'h62);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_idle();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_idle();
      program_phase(ph);
      if (ph == NUM_PHASES - 1) gaps_on = 1'b0;
      if (ph == 4) hold_tog <= ~hold_tog;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        random_seq();
        if (ph == 5 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          drain_idle();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && exp_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: stop_sequence_holdback_filter_core.f
hw/rtl/sshf_pkg.sv
hw/rtl/sshf_calc.sv
hw/rtl/stop_sequence_holdback_filter_core.sv
tb/tb_stop_sequence_holdback_filter_core.sv
